/* hdl/gqed_pkg.sv */
package gqed_pkg;

   // geometry and arithmetic sizing
   localparam int MAX_WIDTH  = 1024;
   localparam int ERROR_BITS = 14;

   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int ROW_BITS     = 16;
   localparam int PIX_BITS     = 8;
   localparam int LEVEL_BITS   = 8;
   localparam int K_CFG_BITS   = 9;
   localparam int W_CFG_BITS   = 11;

   // corrected value 16*v + e, its error against the palette gray and sums of parts
   localparam int OLD_BITS  = ((ERROR_BITS > 13) ? ERROR_BITS : 13) + 1;
   localparam int E_BITS    = OLD_BITS + 1;
   localparam int SUM_BITS  = E_BITS + 1;
   localparam int PART_BITS = E_BITS + 4;
   localparam int PROD_BITS = OLD_BITS + 10;

   // shared divider: 8-bit quotient, dividend below 256 * divisor
   localparam int DIVIDEND_BITS     = 16;
   localparam int LIMIT_BITS        = 16;
   localparam int DIV_BITS_PER_STEP = 4;
   localparam int DIV_STEPS         = LEVEL_BITS / DIV_BITS_PER_STEP;
   localparam int DIV_CNT_BITS      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // diffusion weights in sixteenths
   localparam logic [2:0] W_RIGHT       = 3'd7;
   localparam logic [2:0] W_BELOW_LEFT  = 3'd3;
   localparam logic [2:0] W_BELOW       = 3'd5;
   localparam logic [2:0] W_BELOW_RIGHT = 3'd1;

   // register file
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_COUNT   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DITHER_ENABLE = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_LEVELS    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT  = 3'd4;

   typedef struct packed {
      logic [K_CFG_BITS-1:0] level_count;
      logic                  dither_enable;
      logic [K_CFG_BITS-1:0] num_levels;
      logic [W_CFG_BITS-1:0] image_width;
      logic [ROW_BITS-1:0]   image_height;
   } gqed_cfg_type;

   localparam gqed_cfg_type CFG_RESET = '{
      level_count:   9'd2,
      dither_enable: 1'b0,
      num_levels:    9'd256,
      image_width:   11'd640,
      image_height:  16'd480
   };

   typedef struct packed {
      logic clear_write;
      logic accept;
      logic fetch;
      logic scale;
      logic range;
      logic div_step;
      logic gray_start;
      logic error;
      logic write_here;
      logic write_left;
      logic load_out;
   } gqed_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic index_direct;
      logic div_last;
   } gqed_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_SCALE,
      ST_RANGE,
      ST_DIV_INDEX,
      ST_GRAY_START,
      ST_DIV_GRAY,
      ST_ERROR,
      ST_WRITE_HERE,
      ST_WRITE_LEFT,
      ST_FINISH
   } gqed_state_type;

endpackage

/* hdl/gqed_ram.sv */
module gqed_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 1024,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/gqed_datapath.sv */
module gqed_datapath import gqed_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  gqed_cfg_type          cfg,
   input  gqed_cmd_type          cmd,
   output gqed_status_type       status,
   input  logic [PIX_BITS-1:0]   pixel_gray,
   output logic [LEVEL_BITS-1:0] level_index,
   output logic [LEVEL_BITS-1:0] level_gray,
   output logic                  frame_end
);

   function automatic logic signed [ERROR_BITS-1:0] sat_err(
      input logic signed [SUM_BITS-1:0] v);
      logic fits;
      fits = (v[SUM_BITS-1:ERROR_BITS-1] == {(SUM_BITS-ERROR_BITS+1){v[SUM_BITS-1]}});
      if (fits) begin
         return $signed(v[ERROR_BITS-1:0]);
      end else if (v[SUM_BITS-1]) begin
         return $signed({1'b1, {(ERROR_BITS-1){1'b0}}});
      end else begin
         return $signed({1'b0, {(ERROR_BITS-1){1'b1}}});
      end
   endfunction

   // w/16 of e, rounded half up
   function automatic logic signed [E_BITS-1:0] part16(
      input logic signed [E_BITS-1:0] e,
      input logic [2:0]               wgt);
      logic signed [PART_BITS-1:0] t;
      t = PART_BITS'(e) * PART_BITS'($signed({1'b0, wgt})) + PART_BITS'(8);
      return E_BITS'(t >>> 4);
   endfunction

   // clamped configuration
   logic [LEVEL_BITS-1:0] km1;
   logic [K_CFG_BITS-1:0] nl;
   logic [COL_BITS-1:0]   w_m1;
   logic [ROW_BITS-1:0]   h_m1;

   // position of the arriving pixel
   logic                  col_last;
   logic                  row_last;
   logic [COL_BITS-1:0]   x_acc;
   logic [ROW_BITS-1:0]   y_acc;

   // registers
   logic [PIX_BITS-1:0]          pix_ff, pix_in;
   logic [COL_BITS-1:0]          x_ff, x_in;
   logic [ROW_BITS-1:0]          y_ff, y_in;
   logic                         last_col_ff, last_col_in;
   logic                         last_row_ff, last_row_in;
   logic                         dith_ff, dith_in;
   logic [COL_BITS-1:0]          col_ff, col_in;
   logic [ROW_BITS-1:0]          row_ff, row_in;
   logic signed [ERROR_BITS-1:0] right_ff, right_in;
   logic signed [ERROR_BITS-1:0] diag_ff, diag_in;
   logic signed [ERROR_BITS-1:0] left_ff, left_in;
   logic signed [OLD_BITS-1:0]   old_ff, old_in;
   logic [LIMIT_BITS-1:0]        limit_ff, limit_in;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic                         from_div_ff, from_div_in;
   logic [LEVEL_BITS-1:0]        idx_ff, idx_in;
   logic [LEVEL_BITS-1:0]        gray_ff, gray_in;
   logic signed [E_BITS-1:0]     e_ff, e_in;
   logic [DIVIDEND_BITS-1:0]     div_rem_ff, div_rem_in;
   logic [LEVEL_BITS-1:0]        div_quot_ff, div_quot_in;
   logic [DIVIDEND_BITS-1:0]     div_sh_ff, div_sh_in;
   logic [DIV_CNT_BITS-1:0]      div_cnt_ff, div_cnt_in;
   logic [COL_BITS-1:0]          clr_addr_ff, clr_addr_in;
   logic [LEVEL_BITS-1:0]        out_index_ff, out_index_in;
   logic [LEVEL_BITS-1:0]        out_gray_ff, out_gray_in;
   logic                         out_end_ff, out_end_in;

   // working values
   logic signed [ERROR_BITS-1:0] ram_q;
   logic signed [ERROR_BITS-1:0] incoming;
   logic [LIMIT_BITS:0]          limit_full;
   logic signed [PROD_BITS-1:0]  mul_full;
   logic                         prod_neg;
   logic                         prod_over;
   logic [DIVIDEND_BITS-1:0]     div_r;
   logic [LEVEL_BITS-1:0]        div_q;
   logic [DIVIDEND_BITS-1:0]     div_d;
   logic [LEVEL_BITS-1:0]        idx_sel;
   logic                         spread_down;
   logic signed [ERROR_BITS-1:0] here_val;
   logic signed [ERROR_BITS-1:0] left_val;
   logic                         left_ok;

   // line store port
   logic                         ram_wr_en;
   logic [COL_BITS-1:0]          ram_wr_addr;
   logic [ERROR_BITS-1:0]        ram_wr_data;
   logic [COL_BITS-1:0]          ram_rd_addr;
   logic [ERROR_BITS-1:0]        ram_rd_data;

   always_comb begin
      if (cfg.level_count < 9'd2) begin
         km1 = 8'd1;
      end else if (cfg.level_count > 9'd256) begin
         km1 = 8'd255;
      end else begin
         km1 = LEVEL_BITS'(cfg.level_count - 9'd1);
      end
      if (cfg.num_levels < 9'd2) begin
         nl = 9'd2;
      end else if (cfg.num_levels > 9'd256) begin
         nl = 9'd256;
      end else begin
         nl = cfg.num_levels;
      end
      if (cfg.image_width == '0) begin
         w_m1 = '0;
      end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
         w_m1 = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         w_m1 = COL_BITS'(cfg.image_width - 11'd1);
      end
      h_m1 = (cfg.image_height == '0) ? '0 : cfg.image_height - 16'd1;
   end

   assign col_last = (col_ff >= w_m1);
   assign row_last = (row_ff >= h_m1);
   assign x_acc    = col_last ? w_m1 : col_ff;
   assign y_acc    = row_last ? h_m1 : row_ff;

   assign ram_q      = $signed(ram_rd_data);
   assign incoming   = dith_ff ? sat_err(SUM_BITS'(ram_q) + SUM_BITS'(right_ff)) : '0;
   assign limit_full = (LIMIT_BITS+1)'(km1) * (LIMIT_BITS+1)'(nl);
   assign mul_full   = PROD_BITS'(old_ff) * PROD_BITS'($signed({1'b0, km1}));
   assign prod_neg   = prod_ff[PROD_BITS-1];
   assign prod_over  = (prod_ff[PROD_BITS-2:5] >= (PROD_BITS-6)'(limit_ff));
   assign idx_sel    = from_div_ff ? div_quot_ff : idx_ff;

   // restoring division, several quotient bits per cycle
   always_comb begin
      div_r = div_rem_ff;
      div_q = div_quot_ff;
      div_d = div_sh_ff;
      for (int j = 0; j < DIV_BITS_PER_STEP; j++) begin
         div_q = {div_q[LEVEL_BITS-2:0], 1'b0};
         if (div_r >= div_d) begin
            div_r    = div_r - div_d;
            div_q[0] = 1'b1;
         end
         div_d = div_d >> 1;
      end
   end

   assign spread_down = dith_ff && !last_row_ff;
   assign left_ok     = spread_down && (x_ff != '0);
   assign here_val    = spread_down ?
                        sat_err(SUM_BITS'(diag_ff) + SUM_BITS'(part16(e_ff, W_BELOW))) : '0;
   assign left_val    = sat_err(SUM_BITS'(left_ff) + SUM_BITS'(part16(e_ff, W_BELOW_LEFT)));

   always_comb begin
      pix_in       = pix_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_col_in  = last_col_ff;
      last_row_in  = last_row_ff;
      dith_in      = dith_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      right_in     = right_ff;
      diag_in      = diag_ff;
      left_in      = left_ff;
      old_in       = old_ff;
      limit_in     = limit_ff;
      prod_in      = prod_ff;
      from_div_in  = from_div_ff;
      idx_in       = idx_ff;
      gray_in      = gray_ff;
      e_in         = e_ff;
      div_rem_in   = div_rem_ff;
      div_quot_in  = div_quot_ff;
      div_sh_in    = div_sh_ff;
      div_cnt_in   = div_cnt_ff;
      clr_addr_in  = clr_addr_ff;
      out_index_in = out_index_ff;
      out_gray_in  = out_gray_ff;
      out_end_in   = out_end_ff;

      if (cmd.clear_write) begin
         clr_addr_in = clr_addr_ff + COL_BITS'(1);
      end
      if (cmd.accept) begin
         pix_in      = pixel_gray;
         x_in        = x_acc;
         y_in        = y_acc;
         last_col_in = col_last;
         last_row_in = row_last;
         dith_in     = cfg.dither_enable;
      end
      if (cmd.fetch) begin
         old_in   = OLD_BITS'($signed({1'b0, pix_ff, 4'b0000})) + OLD_BITS'(incoming);
         limit_in = limit_full[LIMIT_BITS-1:0];
      end
      if (cmd.scale) begin
         left_in = ram_q;
         prod_in = (mul_full <<< 1) + PROD_BITS'($signed({1'b0, nl, 4'b0000}));
      end
      if (cmd.range) begin
         idx_in      = prod_neg ? '0 : km1;
         from_div_in = !(prod_neg || prod_over);
         div_rem_in  = prod_ff[DIVIDEND_BITS+4:5];
         div_quot_in = '0;
         div_sh_in   = {nl, {(LEVEL_BITS-1){1'b0}}};
         div_cnt_in  = '0;
      end
      if (cmd.div_step) begin
         div_rem_in  = div_r;
         div_quot_in = div_q;
         div_sh_in   = div_d;
         div_cnt_in  = div_cnt_ff + DIV_CNT_BITS'(1);
      end
      if (cmd.gray_start) begin
         idx_in      = idx_sel;
         div_rem_in  = {idx_sel, {LEVEL_BITS{1'b0}}} - DIVIDEND_BITS'(idx_sel);
         div_quot_in = '0;
         div_sh_in   = {1'b0, km1, {(LEVEL_BITS-1){1'b0}}};
         div_cnt_in  = '0;
      end
      if (cmd.error) begin
         gray_in = div_quot_ff;
         e_in    = E_BITS'(old_ff) - E_BITS'($signed({1'b0, div_quot_ff, 4'b0000}));
      end
      if (cmd.write_here) begin
         right_in = (dith_ff && !last_col_ff) ?
                    sat_err(SUM_BITS'(part16(e_ff, W_RIGHT))) : '0;
         diag_in  = (spread_down && !last_col_ff) ?
                    sat_err(SUM_BITS'(part16(e_ff, W_BELOW_RIGHT))) : '0;
      end
      if (cmd.write_left) begin
         if (last_col_ff) begin
            col_in = '0;
            row_in = last_row_ff ? '0 : y_ff + ROW_BITS'(1);
         end else begin
            col_in = x_ff + COL_BITS'(1);
            row_in = y_ff;
         end
      end
      if (cmd.load_out) begin
         out_index_in = idx_ff;
         out_gray_in  = gray_ff;
         out_end_in   = last_col_ff && last_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         right_ff    <= '0;
         diag_ff     <= '0;
         clr_addr_ff <= '0;
         div_cnt_ff  <= '0;
         from_div_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         right_ff    <= right_in;
         diag_ff     <= diag_in;
         clr_addr_ff <= clr_addr_in;
         div_cnt_ff  <= div_cnt_in;
         from_div_ff <= from_div_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff       <= pix_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      last_col_ff  <= last_col_in;
      last_row_ff  <= last_row_in;
      dith_ff      <= dith_in;
      left_ff      <= left_in;
      old_ff       <= old_in;
      limit_ff     <= limit_in;
      prod_ff      <= prod_in;
      idx_ff       <= idx_in;
      gray_ff      <= gray_in;
      e_ff         <= e_in;
      div_rem_ff   <= div_rem_in;
      div_quot_ff  <= div_quot_in;
      div_sh_ff    <= div_sh_in;
      out_index_ff <= out_index_in;
      out_gray_ff  <= out_gray_in;
      out_end_ff   <= out_end_in;
   end

   // line store access
   always_comb begin
      ram_wr_en   = cmd.clear_write || cmd.write_here || (cmd.write_left && left_ok);
      ram_wr_addr = x_ff;
      ram_wr_data = here_val;
      if (cmd.clear_write) begin
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else if (cmd.write_left) begin
         ram_wr_addr = x_ff - COL_BITS'(1);
         ram_wr_data = left_val;
      end
      ram_rd_addr = cmd.accept ? x_acc : x_ff - COL_BITS'(1);
   end

   gqed_ram #(
      .WIDTH (ERROR_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign status.clear_done   = (clr_addr_ff == COL_BITS'(MAX_WIDTH - 1));
   assign status.index_direct = prod_neg || prod_over;
   assign status.div_last     = (div_cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1));

   assign level_index = out_index_ff;
   assign level_gray  = out_gray_ff;
   assign frame_end   = out_end_ff;

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.write_here |-> (idx_ff <= km1))
      else $error("level index above top level");

   a_top_level_gray: assert property (@(posedge clock) disable iff (reset)
      (cmd.write_here && (idx_ff == km1)) |-> (gray_ff == '1))
      else $error("top level does not map to full gray");

endmodule

/* hdl/gqed_ctrl.sv */
module gqed_ctrl import gqed_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output gqed_cmd_type    cmd,
   input  gqed_status_type status
);

   gqed_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_RANGE;
         end
         ST_RANGE: begin
            cmd.range = 1'b1;
            state_in  = status.index_direct ? ST_GRAY_START : ST_DIV_INDEX;
         end
         ST_DIV_INDEX: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_GRAY_START;
            end
         end
         ST_GRAY_START: begin
            cmd.gray_start = 1'b1;
            state_in       = ST_DIV_GRAY;
         end
         ST_DIV_GRAY: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_ERROR;
            end
         end
         ST_ERROR: begin
            cmd.error = 1'b1;
            state_in  = ST_WRITE_HERE;
         end
         ST_WRITE_HERE: begin
            cmd.write_here = 1'b1;
            state_in       = ST_WRITE_LEFT;
         end
         ST_WRITE_LEFT: begin
            cmd.write_left = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_out))
      else $error("result valid without a result load");

endmodule

/* hdl/gray_quantizer_error_diffusion.sv */
// Gray quantizer with Floyd-Steinberg error diffusion. Takes 8-bit gray pixels in raster
// order on the req_ channel and returns one result per pixel on the rsp_ channel: the
// level index round(v*(k-1)/num_levels) clamped to 0..k-1, its palette gray
// index*255/(k-1) and a frame-end flag on the last pixel of the frame. With dithering on,
// the error (in 1/16 gray, saturated to 14 bits) is spread 7/16 right and 3/16, 5/16,
// 1/16 into the next row through a 1024-entry line store. After reset the line store is
// swept to zero, one entry per cycle; req_stall stays high meanwhile, csr writes are
// taken as ever. Each pixel runs through the shared divider (4 quotient bits a cycle),
// once for the index unless it is below zero or at the top level and once for the
// palette gray, and through the single read and write port of the line store, which
// reads two entries and writes up to two per pixel. The result sits in an output
// register, so the next pixel is taken while the previous result still waits. csr
// registers must be written by the user only while the block is idle; the block itself
// does not enforce this, and they act on the next pixel.
module gray_quantizer_error_diffusion import gqed_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // pixel input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PIX_BITS-1:0]       req_pixel_gray,
   // result output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [LEVEL_BITS-1:0]     rsp_level_index,
   output logic [LEVEL_BITS-1:0]     rsp_level_gray,
   output logic                      rsp_frame_end,
   // register writes
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   gqed_cfg_type    cfg_ff, cfg_in;
   gqed_cmd_type    cmd;
   gqed_status_type status;

   // register file, raw values; the datapath clamps them into range
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LEVEL_COUNT:   cfg_in.level_count   = csr_data[K_CFG_BITS-1:0];
            CSR_DITHER_ENABLE: cfg_in.dither_enable = csr_data[0];
            CSR_NUM_LEVELS:    cfg_in.num_levels    = csr_data[K_CFG_BITS-1:0];
            CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_data[W_CFG_BITS-1:0];
            CSR_IMAGE_HEIGHT:  cfg_in.image_height  = csr_data[ROW_BITS-1:0];
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: clear sweep, then one pixel at a time through the datapath
   gqed_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // quantizer arithmetic, shared divider, error state and line store
   gqed_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd         (cmd),
      .status      (status),
      .pixel_gray  (req_pixel_gray),
      .level_index (rsp_level_index),
      .level_gray  (rsp_level_gray),
      .frame_end   (rsp_frame_end)
   );

endmodule
